>>> rtl/hsif_pkg.sv
package hsif_pkg;

  localparam int KeyW     = 64;
  localparam int SlotW    = 12;
  localparam int StatusW  = 3;
  localparam int SizeLogW = 4;
  localparam int HalfW    = KeyW / 2;
  localparam int MixShift = 33;

  localparam logic [SizeLogW-1:0] SizeLogReset = 4'd12;
  localparam logic [SizeLogW-1:0] SizeLogMin   = 4'd4;

  localparam logic [KeyW-1:0] MixConst1 = 64'hff51afd7ed558ccd;
  localparam logic [KeyW-1:0] MixConst2 = 64'hc4ceb9fe1a85ec53;

  typedef logic [StatusW-1:0] status_t;

  localparam status_t StatFound  = 3'd0;
  localparam status_t StatNew    = 3'd1;
  localparam status_t StatAbsent = 3'd2;
  localparam status_t StatFull   = 3'd3;
  localparam status_t StatReject = 3'd4;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdFind   = 1'b1;

  typedef enum logic [1:0] {
    MulLoLo = 2'd0,
    MulLoHi = 2'd1,
    MulHiLo = 2'd2
  } hsif_mul_step_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StMul,
    StMix,
    StRead,
    StCheck
  } hsif_state_e;

endpackage

>>> rtl/hash_set_insert_find.sv
// A rejected key (all ones) gives its result strobe in the cycle after the transfer.
// Otherwise the hash takes six 32x32 multiplier passes and two mixing steps, then each
// probed slot takes one read and one compare step on the single store read port; from 1
// up to the active table size slots are probed. Throughput: one command at a time; busy
// is high until the cycle of the result strobe, and stays low for a rejected key.
// Reset clears every store entry in turn with busy high; results cannot be stalled.
module hash_set_insert_find #(
  parameter int TABLE_LOG = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd_i,
  input  logic [hsif_pkg::KeyW-1:0]      key_i,
  output logic                           done_o,
  output logic [hsif_pkg::SlotW-1:0]     slot_o,
  output logic [hsif_pkg::StatusW-1:0]   status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hsif_pkg::SizeLogW-1:0]  cfg_data_i
);
  import hsif_pkg::*;

  localparam int Depth = 2 ** TABLE_LOG;

  hsif_state_e state_q, state_d;

  logic [SizeLogW-1:0]  size_log_q;
  logic [TABLE_LOG-1:0] clr_cnt_q, clr_cnt_d;
  logic [TABLE_LOG-1:0] pos_q, pos_d;
  logic [TABLE_LOG-1:0] cnt_q, cnt_d;
  logic [TABLE_LOG-1:0] mask_q, mask_d;
  logic [KeyW-1:0]      x_q, x_d;
  logic [KeyW-1:0]      acc_q, acc_d;
  logic [KeyW-1:0]      code_q, code_d;
  logic                 cmd_q, cmd_d;
  logic                 round_q, round_d;
  hsif_mul_step_e       step_q, step_d;

  logic                 done_q, done_d;
  logic [TABLE_LOG-1:0] res_slot_q, res_slot_d;
  status_t              res_status_q, res_status_d;

  logic [KeyW-1:0]      store_mem [Depth];
  logic [KeyW-1:0]      rdata_q;
  logic                 mem_we;
  logic [TABLE_LOG-1:0] mem_waddr;
  logic [KeyW-1:0]      mem_wdata;

  logic                 accept;
  logic [SizeLogW-1:0]  lg;
  logic [HalfW-1:0]     mul_a, mul_b;
  logic [KeyW-1:0]      mul_const;
  logic [KeyW-1:0]      prod;
  logic [KeyW-1:0]      mixed;
  logic [TABLE_LOG+SlotW-1:0] slot_ext;

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    lg = size_log_q;
    if (size_log_q < SizeLogMin) begin
      lg = SizeLogMin;
    end else if (int'(size_log_q) > TABLE_LOG) begin
      lg = SizeLogW'(TABLE_LOG);
    end
    for (int i = 0; i < TABLE_LOG; i++) begin
      mask_d[i] = (i < int'(lg));
    end
  end

  // One shared 32x32 multiplier builds the low 64 bits of x times a constant in three passes.
  assign mul_const = round_q ? MixConst2 : MixConst1;
  assign mul_a     = (step_q == MulHiLo) ? x_q[KeyW-1:HalfW] : x_q[HalfW-1:0];
  assign mul_b     = (step_q == MulLoHi) ? mul_const[KeyW-1:HalfW] : mul_const[HalfW-1:0];
  assign prod      = KeyW'(mul_a) * KeyW'(mul_b);
  assign mixed     = acc_q ^ (acc_q >> MixShift);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (&clr_cnt_q) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept && !(&key_i)) begin
          state_d = StMul;
        end
      end
      StMul: begin
        if (step_q == MulHiLo) begin
          state_d = StMix;
        end
      end
      StMix: begin
        state_d = round_q ? StRead : StMul;
      end
      StRead: begin
        state_d = StCheck;
      end
      StCheck: begin
        if (rdata_q == code_q || rdata_q == '0 || cnt_q == mask_q) begin
          state_d = StIdle;
        end else begin
          state_d = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    clr_cnt_d    = clr_cnt_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    x_d          = x_q;
    acc_d        = acc_q;
    code_d       = code_q;
    cmd_d        = cmd_q;
    round_d      = round_q;
    step_d       = step_q;
    done_d       = 1'b0;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_q;
    mem_wdata    = code_q;
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      StIdle: begin
        if (accept) begin
          if (&key_i) begin
            done_d       = 1'b1;
            res_slot_d   = '0;
            res_status_d = StatReject;
          end else begin
            x_d     = key_i ^ (key_i >> MixShift);
            code_d  = key_i + 1'b1;
            cmd_d   = cmd_i;
            round_d = 1'b0;
            step_d  = MulLoLo;
          end
        end
      end
      StMul: begin
        unique case (step_q)
          MulLoLo: begin
            acc_d  = prod;
            step_d = MulLoHi;
          end
          MulLoHi: begin
            acc_d  = {acc_q[KeyW-1:HalfW] + prod[HalfW-1:0], acc_q[HalfW-1:0]};
            step_d = MulHiLo;
          end
          MulHiLo: begin
            acc_d  = {acc_q[KeyW-1:HalfW] + prod[HalfW-1:0], acc_q[HalfW-1:0]};
            step_d = MulLoLo;
          end
          default: begin
            step_d = MulLoLo;
          end
        endcase
      end
      StMix: begin
        if (round_q) begin
          pos_d = mixed[TABLE_LOG-1:0] & mask_q;
          cnt_d = '0;
        end else begin
          x_d     = mixed;
          round_d = 1'b1;
        end
      end
      StRead: begin
      end
      StCheck: begin
        if (rdata_q == code_q) begin
          done_d       = 1'b1;
          res_slot_d   = pos_q;
          res_status_d = StatFound;
        end else if (rdata_q == '0) begin
          done_d = 1'b1;
          if (cmd_q == CmdInsert) begin
            mem_we       = 1'b1;
            res_slot_d   = pos_q;
            res_status_d = StatNew;
          end else begin
            res_slot_d   = '0;
            res_status_d = StatAbsent;
          end
        end else if (cnt_q == mask_q) begin
          done_d       = 1'b1;
          res_slot_d   = '0;
          res_status_d = (cmd_q == CmdFind) ? StatAbsent : StatFull;
        end else begin
          pos_d = (pos_q + 1'b1) & mask_q;
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_cnt_q  <= '0;
      size_log_q <= SizeLogReset;
      done_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_log_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cnt_q        <= cnt_d;
    x_q          <= x_d;
    acc_q        <= acc_d;
    code_q       <= code_d;
    cmd_q        <= cmd_d;
    round_q      <= round_d;
    step_q       <= step_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    if (state_q == StIdle) begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= store_mem[pos_q];
  end

  assign slot_ext = {{SlotW{1'b0}}, res_slot_q};
  assign slot_o   = slot_ext[SlotW-1:0];
  assign status_o = res_status_q;
  assign done_o   = done_q;

endmodule

>>> tb/hash_set_insert_find_test.sv
`timescale 1ns / 100ps

module hash_set_insert_find_test;
  import hsif_pkg::*;

  localparam int TableLog  = 12;
  localparam int TableSize = 1 << TableLog;

  typedef struct packed {
    logic            cmd;
    logic [KeyW-1:0] key;
  } lookup_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    status_t          status;
  } outcome_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic                cmd_i       = CmdInsert;
  logic [KeyW-1:0]     key_i       = '0;
  logic                done_o;
  logic [SlotW-1:0]    slot_o;
  logic [StatusW-1:0]  status_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SizeLogW-1:0] cfg_data_i  = '0;

  logic [KeyW-1:0]     shadow_slots [TableSize] = '{default: '0};
  logic [SizeLogW-1:0] size_reg = SizeLogReset;

  lookup_t         queued_lookups [$];
  outcome_t        expected_outcomes [$];
  logic [KeyW-1:0] key_pool [$];
  int              idle_pct   = 0;
  int              mismatches = 0;
  logic            loaded     = 1'b0;

  hash_set_insert_find #(
    .TABLE_LOG(TableLog)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .key_i      (key_i),
    .done_o     (done_o),
    .slot_o     (slot_o),
    .status_o   (status_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [KeyW-1:0] fmix_key(logic [KeyW-1:0] k);
    logic [KeyW-1:0] x;
    x = k;
    x = x ^ (x >> MixShift);
    x = x * MixConst1;
    x = x ^ (x >> MixShift);
    x = x * MixConst2;
    x = x ^ (x >> MixShift);
    return x;
  endfunction

  // Walks the shadow table the way the block does and applies any insertion.
  function automatic outcome_t probe_table(logic c, logic [KeyW-1:0] k);
    outcome_t        res;
    int              lg;
    int unsigned     msk;
    int unsigned     pos;
    int unsigned     n;
    logic [KeyW-1:0] code;
    logic [KeyW-1:0] cur;
    res.slot = '0;
    if (k == '1) begin
      res.status = StatReject;
      return res;
    end
    lg = int'(size_reg);
    if (lg < int'(SizeLogMin)) lg = int'(SizeLogMin);
    if (lg > TableLog) lg = TableLog;
    msk = (32'd1 << lg) - 1;
    code = k + 1;
    pos = 32'(fmix_key(k)) & msk;
    res.status = (c == CmdInsert) ? StatFull : StatAbsent;
    for (n = 0; n <= msk; n++) begin
      cur = shadow_slots[pos];
      if (cur == code) begin
        res.slot = SlotW'(pos);
        res.status = StatFound;
        break;
      end
      if (cur == '0) begin
        if (c == CmdInsert) begin
          shadow_slots[pos] = code;
          res.slot = SlotW'(pos);
          res.status = StatNew;
        end else begin
          res.status = StatAbsent;
        end
        break;
      end
      pos = (pos + 1) & msk;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    lookup_t nxt;
    if (start && !busy) begin
      expected_outcomes.push_back(probe_table(cmd_i, key_i));
      loaded = 1'b0;
    end
    if (!loaded && rst_ni && queued_lookups.size() != 0 &&
        $urandom_range(99) >= idle_pct) begin
      nxt = queued_lookups.pop_front();
      cmd_i <= nxt.cmd;
      key_i <= nxt.key;
      loaded = 1'b1;
    end
    start <= loaded;
  end

  always @(posedge clk_i) begin
    outcome_t exp;
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: slot %0d status %0d", slot_o, status_o);
        mismatches++;
      end else begin
        exp = expected_outcomes.pop_front();
        if (slot_o !== exp.slot) begin
          $error("slot: expected %0d, actual %0d", exp.slot, slot_o);
          mismatches++;
        end
        if (status_o !== exp.status) begin
          $error("status: expected %0d, actual %0d", exp.status, status_o);
          mismatches++;
        end
      end
    end
  end

  task automatic queue_lookup(input logic c, input logic [KeyW-1:0] k);
    lookup_t it;
    it.cmd = c;
    it.key = k;
    queued_lookups.push_back(it);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (queued_lookups.size() != 0 || loaded || expected_outcomes.size() != 0);
  endtask

  task automatic write_size_log(input logic [SizeLogW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (cfg_ready_o !== 1'b1);
    size_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [KeyW-1:0] draw_key();
    int unsigned     r;
    logic [KeyW-1:0] k;
    r = $urandom_range(99);
    if (r < 4) begin
      k = '1;
    end else if (r < 10) begin
      case ($urandom_range(3))
        0: k = '0;
        1: k = {{(KeyW-1){1'b1}}, 1'b0};
        2: k = {1'b1, {(KeyW-1){1'b0}}};
        default: k = KeyW'($urandom_range(31));
      endcase
    end else if (r < 55 && key_pool.size() != 0) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end else begin
      k = {$urandom, $urandom};
      key_pool.push_back(k);
      if (key_pool.size() > 256) key_pool.delete(0);
    end
    return k;
  endfunction

  task automatic run_phase(input logic [SizeLogW-1:0] size_val, input int idle,
                           input int count);
    write_size_log(size_val);
    idle_pct = idle;
    repeat (count) begin
      queue_lookup(($urandom_range(99) < 60) ? CmdInsert : CmdFind, draw_key());
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full-size table straight after the clearing pass.
    queue_lookup(CmdInsert, '0);
    queue_lookup(CmdFind, '0);
    queue_lookup(CmdInsert, '0);
    queue_lookup(CmdFind, 64'd1);
    queue_lookup(CmdInsert, '1);
    queue_lookup(CmdFind, '1);
    queue_lookup(CmdInsert, {{(KeyW-1){1'b1}}, 1'b0});
    queue_lookup(CmdInsert, {1'b1, {(KeyW-1){1'b0}}});
    wait_drained();

    // Smallest table: seventeen distinct keys must overflow it.
    write_size_log(SizeLogMin);
    for (int i = 0; i < 17; i++) queue_lookup(CmdInsert, 64'h100 + KeyW'(i));
    queue_lookup(CmdFind, 64'h5a5a_5a5a_0000_0001);
    wait_drained();

    run_phase(4'd0, 0, 150);
    run_phase(4'd15, 80, 300);
    run_phase(4'd4, 12, 150);
    run_phase(4'd7, 80, 200);
    run_phase(4'd12, 0, 300);
    run_phase(4'd3, 12, 100);
    run_phase(4'd13, 12, 200);
    run_phase(4'd5, 80, 100);
    run_phase(4'd9, 0, 100);

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
rtl/hsif_pkg.sv
rtl/hash_set_insert_find.sv
tb/hash_set_insert_find_test.sv
